// ----- design/local_directional_pattern_code_macros.svh -----
// ----------------------------------------------------------------------------
// Local directional pattern code - assertion macros
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef LOCAL_DIRECTIONAL_PATTERN_CODE_MACROS_SVH
`define LOCAL_DIRECTIONAL_PATTERN_CODE_MACROS_SVH

`ifndef SYNTHESIS
`define LDPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LDPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("assertion failed");
`else
`define LDPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LDPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/ldpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Local directional pattern code - package
// Fixed widths, compass direction taps and the pattern rank table.
// ----------------------------------------------------------------------------
package ldpc_pkg;

    localparam int PIX_W  = 16;
    localparam int NDIR   = 8;
    localparam int NTAP   = 3;
    localparam int KSEL   = 3;
    localparam int CODE_W = 6;

    typedef enum logic [2:0] {
        NB_NW = 3'd0,
        NB_N  = 3'd1,
        NB_NE = 3'd2,
        NB_W  = 3'd3,
        NB_E  = 3'd4,
        NB_SW = 3'd5,
        NB_S  = 3'd6,
        NB_SE = 3'd7
    } nb_t;

    typedef nb_t dir_taps_t [NDIR][NTAP];

    localparam dir_taps_t DIR_TAPS = '{
        '{NB_NE, NB_E,  NB_SE},
        '{NB_N,  NB_NE, NB_E },
        '{NB_NW, NB_N,  NB_NE},
        '{NB_NW, NB_N,  NB_W },
        '{NB_NW, NB_W,  NB_SW},
        '{NB_W,  NB_SW, NB_S },
        '{NB_SW, NB_S,  NB_SE},
        '{NB_E,  NB_S,  NB_SE}
    };

    function automatic logic [CODE_W-1:0] rank_of_pattern(input logic [NDIR-1:0] pattern);
        logic [CODE_W-1:0] rank;
        logic [CODE_W-1:0] idx;
        logic [NDIR-1:0]   p;
        rank = '0;
        idx  = '0;
        for (int a = 7; a >= 2; a--) begin
            for (int b = a - 1; b >= 1; b--) begin
                for (int c = b - 1; c >= 0; c--) begin
                    p = NDIR'((1 << a) | (1 << b) | (1 << c));
                    if (p == pattern) begin
                        rank = idx;
                    end
                    idx = idx + 1'b1;
                end
            end
        end
        return rank;
    endfunction

endpackage

// ----- design/ldpc_front.sv -----
// ----------------------------------------------------------------------------
// Local directional pattern code - front end
// Accepts a neighborhood beat and registers the eight directional tap sums.
// ----------------------------------------------------------------------------
module ldpc_front
    import ldpc_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          push_ready,
    input  logic [NDIR-1:0][PIX_W-1:0]    pix,
    output logic                          push_valid,
    output logic [NDIR-1:0][PIXEL_BITS+1:0] sums
);

    localparam int SW = PIXEL_BITS + 2;

    logic                   valid_reg;
    logic                   valid_next;
    logic [NDIR-1:0][SW-1:0] sums_reg;
    logic [NDIR-1:0][SW-1:0] sums_next;

    always_comb
    begin
        for (int d = 0; d < NDIR; d++)
        begin
            sums_next[d] = '0;
            for (int t = 0; t < NTAP; t++)
            begin
                sums_next[d] = sums_next[d]
                             + SW'(pix[DIR_TAPS[d][t]][PIXEL_BITS-1:0]);
            end
        end
        valid_next = accept | (valid_reg & ~push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sums_reg <= sums_next;
        end
    end

    assign push_valid = valid_reg;
    assign sums       = sums_reg;

endmodule

// ----- design/ldpc_queue.sv -----
// ----------------------------------------------------------------------------
// Local directional pattern code - decoupling queue
// Two-entry queue of tap sums between the front end and the back end.
// ----------------------------------------------------------------------------
module ldpc_queue
    import ldpc_pkg::*;
#(
    parameter int W = 144
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [W-1:0] mem_reg [DEPTH];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    always_comb
    begin
        push_ready  = (count_reg != 2'(DEPTH));
        pop_valid   = (count_reg != 2'd0);
        do_push     = push_valid & push_ready;
        do_pop      = pop_valid & pop_ready;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
        pop_data    = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/ldpc_back.sv -----
// ----------------------------------------------------------------------------
// Local directional pattern code - back end
// Ranks the directional sums, picks the three strongest and encodes them.
// ----------------------------------------------------------------------------
module ldpc_back
    import ldpc_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [NDIR-1:0][PIXEL_BITS+1:0] sums,
    output logic                            done,
    output logic [CODE_W-1:0]               pattern_code,
    output logic [NDIR-1:0]                 pattern_bits
);

    logic                      s1_valid_reg;
    logic [NDIR-1:0][NDIR-1:0] beat_reg;
    logic [NDIR-1:0][NDIR-1:0] beat_next;
    logic                      done_reg;
    logic [CODE_W-1:0]         code_reg;
    logic [CODE_W-1:0]         code_next;
    logic [NDIR-1:0]           bits_reg;
    logic [NDIR-1:0]           bits_next;
    logic [3:0]                cnt;

    // A direction is outranked by a larger sum, or by an equal sum at a lower direction.
    always_comb
    begin
        for (int d = 0; d < NDIR; d++)
        begin
            for (int e = 0; e < NDIR; e++)
            begin
                if (e < d)
                begin
                    beat_next[d][e] = (sums[e] >= sums[d]);
                end
                else if (e > d)
                begin
                    beat_next[d][e] = (sums[e] > sums[d]);
                end
                else
                begin
                    beat_next[d][e] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        bits_next = '0;
        cnt       = '0;
        for (int d = 0; d < NDIR; d++)
        begin
            cnt = '0;
            for (int e = 0; e < NDIR; e++)
            begin
                cnt = cnt + 4'(beat_reg[d][e]);
            end
            bits_next[NDIR-1-d] = (cnt < 4'(KSEL));
        end
        code_next = rank_of_pattern(bits_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            beat_reg <= beat_next;
        end
        if (s1_valid_reg)
        begin
            code_reg <= code_next;
            bits_reg <= bits_next;
        end
    end

    assign in_ready     = 1'b1;
    assign done         = done_reg;
    assign pattern_code = code_reg;
    assign pattern_bits = bits_reg;

endmodule

// ----- design/local_directional_pattern_code.sv -----
// ----------------------------------------------------------------------------
// Local directional pattern code - top level
// Kirsch compass pattern code of a 3x3 neighborhood, three strongest directions.
// ----------------------------------------------------------------------------
// done follows an accepted beat via sum, queue, compare and encode registers.
// Throughput: one beat per cycle; busy stays low because the back end never stalls.
// The rate is set by the registered tap adder in the front end and the
// two-stage compare and encode pipeline in the back end.
// Reset: rst_n clears all valid flags and queue pointers at once; no clearing pass.
`include "local_directional_pattern_code_macros.svh"

module local_directional_pattern_code
    import ldpc_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [PIX_W-1:0]   pix_nw,
    input  logic [PIX_W-1:0]   pix_n,
    input  logic [PIX_W-1:0]   pix_ne,
    input  logic [PIX_W-1:0]   pix_w,
    input  logic [PIX_W-1:0]   pix_e,
    input  logic [PIX_W-1:0]   pix_sw,
    input  logic [PIX_W-1:0]   pix_s,
    input  logic [PIX_W-1:0]   pix_se,
    output logic               done,
    output logic [CODE_W-1:0]  pattern_code,
    output logic [NDIR-1:0]    pattern_bits
);

    localparam int SW = PIXEL_BITS + 2;
    localparam int QW = NDIR * SW;

    logic [NDIR-1:0][PIX_W-1:0] pix;
    logic                       accept;
    logic                       push_valid;
    logic                       push_ready;
    logic [NDIR-1:0][SW-1:0]    front_sums;
    logic                       pop_valid;
    logic                       pop_ready;
    logic [QW-1:0]              pop_data;

    always_comb
    begin
        pix[NB_NW] = pix_nw;
        pix[NB_N]  = pix_n;
        pix[NB_NE] = pix_ne;
        pix[NB_W]  = pix_w;
        pix[NB_E]  = pix_e;
        pix[NB_SW] = pix_sw;
        pix[NB_S]  = pix_s;
        pix[NB_SE] = pix_se;
    end

    assign busy   = push_valid & ~push_ready;
    assign accept = start & ~busy;

    ldpc_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .push_ready (push_ready),
        .pix        (pix),
        .push_valid (push_valid),
        .sums       (front_sums)
    );

    ldpc_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (QW'(front_sums)),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ldpc_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pop_valid),
        .in_ready     (pop_ready),
        .sums         (pop_data),
        .done         (done),
        .pattern_code (pattern_code),
        .pattern_bits (pattern_bits)
    );

    `LDPC_ASSERT_IMP(a_three_bits, clk, rst_n, done, $countones(pattern_bits) == 3)
    `LDPC_ASSERT_IMP(a_code_range, clk, rst_n, done, pattern_code <= 6'd55)
    `LDPC_ASSERT_NXT(a_latency, clk, rst_n, accept, ##3 done)
    `LDPC_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Local directional pattern code - testbench
// Drives 3x3 neighborhoods through the start/busy handshake in random bursts.
// A behavioral Kirsch model predicts each pattern. Every done strobe is
// checked in order against the predicted code and raw bits.
// ----------------------------------------------------------------------------
module testbench;

    import ldpc_pkg::*;

    localparam int PIXEL_BITS  = 16;
    localparam int RANDOM_BEATS = 500;
    localparam int MAX_REPORTS = 10;

    typedef logic [7:0][PIX_W-1:0] window_t;

    typedef struct packed {
        bit      drain_first;
        window_t px;
    } window_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [NDIR-1:0]   bits;
    } pattern_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    window_t           drive_px = '0;
    logic              busy;
    logic              done;
    logic [CODE_W-1:0] pattern_code;
    logic [NDIR-1:0]   pattern_bits;

    window_beat_t      pending_q[$];
    pattern_t          expected_q[$];
    int                gap_left = 0;
    int                burst_left = 0;
    int                sent = 0;
    int                checked = 0;
    int                mismatches = 0;
    int                directed_beats = 0;
    bit   [63:0]       codes_seen = '0;

    local_directional_pattern_code #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pix_nw       (drive_px[NB_NW]),
        .pix_n        (drive_px[NB_N]),
        .pix_ne       (drive_px[NB_NE]),
        .pix_w        (drive_px[NB_W]),
        .pix_e        (drive_px[NB_E]),
        .pix_sw       (drive_px[NB_SW]),
        .pix_s        (drive_px[NB_S]),
        .pix_se       (drive_px[NB_SE]),
        .done         (done),
        .pattern_code (pattern_code),
        .pattern_bits (pattern_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Compass responses are 8 times the direction sum minus 3 times the ring sum.
    // The three strongest win, ties to the lower direction, and the code is the
    // number of three-bit patterns numerically above the chosen one.
    function automatic pattern_t kirsch_pattern(window_t win);
        int          px [8];
        int          ring_sum;
        int          dir_sum;
        int          resp [NDIR];
        bit          taken [NDIR];
        int          best;
        int          above;
        logic [NDIR-1:0] bits;
        pattern_t    r;
        ring_sum = 0;
        for (int i = 0; i < 8; i++)
        begin
            px[i] = int'(win[i]) & ((1 << PIXEL_BITS) - 1);
            ring_sum += px[i];
        end
        for (int d = 0; d < NDIR; d++)
        begin
            case (d)
                0: dir_sum = px[NB_NE] + px[NB_E]  + px[NB_SE];
                1: dir_sum = px[NB_N]  + px[NB_NE] + px[NB_E];
                2: dir_sum = px[NB_NW] + px[NB_N]  + px[NB_NE];
                3: dir_sum = px[NB_NW] + px[NB_N]  + px[NB_W];
                4: dir_sum = px[NB_NW] + px[NB_W]  + px[NB_SW];
                5: dir_sum = px[NB_W]  + px[NB_SW] + px[NB_S];
                6: dir_sum = px[NB_SW] + px[NB_S]  + px[NB_SE];
                default: dir_sum = px[NB_E] + px[NB_S] + px[NB_SE];
            endcase
            resp[d]  = 8 * dir_sum - 3 * ring_sum;
            taken[d] = 1'b0;
        end
        bits = '0;
        for (int k = 0; k < KSEL; k++)
        begin
            best = -1;
            for (int d = 0; d < NDIR; d++)
            begin
                if (!taken[d] && (best < 0 || resp[d] > resp[best]))
                    best = d;
            end
            taken[best]    = 1'b1;
            bits[7 - best] = 1'b1;
        end
        above = 0;
        for (int v = 255; v > int'(bits); v--)
        begin
            if ($countones(v) == 3)
                above++;
        end
        r.code = CODE_W'(above);
        r.bits = bits;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%t: %s", $realtime, msg);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin : drive_proc
        window_beat_t beat;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_q = {expected_q, kirsch_pattern(drive_px)};
                sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left--;
                end
                else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && expected_q.size() != 0))
                begin
                    start <= 1'b0;
                end
                else
                begin
                    beat = pending_q.pop_front();
                    drive_px <= beat.px;
                    start    <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_proc
        pattern_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat: code %0d bits %b",
                                        pattern_code, pattern_bits));
            end
            else
            begin
                want = expected_q.pop_front();
                checked++;
                codes_seen[pattern_code] = 1'b1;
                if (pattern_code !== want.code)
                    note_mismatch($sformatf("pattern_code: expected %0d, got %0d",
                                            want.code, pattern_code));
                if (pattern_bits !== want.bits)
                    note_mismatch($sformatf("pattern_bits: expected %b, got %b",
                                            want.bits, pattern_bits));
            end
        end
    end

    initial
    begin : stim_proc
        window_beat_t beat;
        int           kind;
        int           base;
        beat = '0;
        pending_q = {pending_q, beat};
        beat.px = '1;
        pending_q = {pending_q, beat};
        for (int i = 0; i < 8; i++)
        begin
            beat.px    = '0;
            beat.px[i] = '1;
            pending_q = {pending_q, beat};
            beat.px    = '1;
            beat.px[i] = '0;
            pending_q = {pending_q, beat};
        end
        // The south-east corner dominates, selecting the last set of the table.
        beat.px = '0;
        beat.px[NB_W]  = '1;
        beat.px[NB_SW] = '1;
        beat.px[NB_S]  = '1;
        beat.px[NB_SE] = '1;
        beat.px[NB_E]  = '1;
        pending_q = {pending_q, beat};
        // Equal nonzero samples tie every direction.
        beat.px = {8{16'h1234}};
        pending_q = {pending_q, beat};
        directed_beats = pending_q.size();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            kind = $urandom_range(0, 3);
            base = $urandom_range(0, 65000);
            beat.drain_first = (n == 0) || ($urandom_range(0, 99) == 0);
            for (int i = 0; i < 8; i++)
            begin
                case (kind)
                    0: beat.px[i] = PIX_W'($urandom);
                    1: beat.px[i] = PIX_W'($urandom_range(0, 3));
                    2: beat.px[i] = $urandom_range(0, 1) ? '1 : '0;
                    default: beat.px[i] = PIX_W'(base + $urandom_range(0, 500));
                endcase
            end
            pending_q = {pending_q, beat};
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_q.size() != 0 || start || expected_q.size() != 0);
        repeat (10) @(posedge clk);

        $display("Checked %0d of %0d windows (%0d directed, %0d random) in random bursts.",
                 checked, sent, directed_beats, RANDOM_BEATS);
        $display("Saw %0d of 56 pattern codes; %0d field mismatches.",
                 $countones(codes_seen), mismatches);
        if (mismatches == 0 && checked == sent)
            $display("local_directional_pattern_code: match");
        else
            $display("local_directional_pattern_code: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", expected_q.size());
        $display("local_directional_pattern_code: mismatch");
        $finish;
    end

endmodule
